/* rtl/core/rpbc_pkg.sv */
package rpbc_pkg;

  localparam int ENTRIES = 8192;
  localparam int PROBES  = 8;

  localparam int IDX_W  = $clog2(ENTRIES);
  localparam int PCNT_W = $clog2(PROBES + 1);

  localparam logic [IDX_W-1:0]  LAST_SLOT  = IDX_W'(ENTRIES - 1);
  localparam logic [PCNT_W-1:0] LAST_PROBE = PCNT_W'(PROBES - 1);
  localparam logic [PCNT_W-1:0] END_PROBE  = PCNT_W'(PROBES);

  localparam logic CMD_LOOKUP = 1'b0;
  localparam logic CMD_ADD    = 1'b1;

  typedef struct packed {
    logic load;
    logic probe;
    logic clear;
    logic wr_entry;
    logic wr_first;
    logic zero_step;
    logic count_hit;
    logic count_miss;
    logic finish;
  } rpbc_cmd_t;

  typedef struct packed {
    logic clear_last;
    logic is_add;
    logic chk_valid;
    logic hit;
    logic add_ok;
    logic chk_last;
    logic zero_last;
  } rpbc_status_t;

  // one rehash step on 32 bits, masked to the table size
  function automatic logic [IDX_W-1:0] next_slot(input logic [31:0] v);
    logic [31:0] h;
    h = (v >> 16) ^ (v << 3) ^ v;
    return h[IDX_W-1:0];
  endfunction

endpackage

/* rtl/core/rehash_probe_block_cache_core.sv */
// block number cache, logical to physical, in an open addressed table of ENTRIES slots
// walked by rehash probing (at most PROBES slots). after reset the table is cleared
// one slot a cycle, with busy high. a request is taken when start is high and busy
// low; busy then stays high while the probe chain is walked, one slot a cycle
// through the single port tag and physical memories: a lookup stops at the first hit
// or after PROBES slots, an add at the first empty or matching slot, or when the
// chain is full it writes the first slot and clears the later slots. the result sits
// on the outputs for the single cycle done is high, right after busy falls, and must
// be taken then; hit_total and miss_total are valid in that cycle.
module rehash_probe_block_cache_core (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  output logic        busy,
  input  logic        command,
  input  logic [31:0] logical_block,
  input  logic [31:0] new_physical_block,
  output logic        done,
  output logic [31:0] found_block,
  output logic        hit,
  output logic [31:0] hit_total,
  output logic [31:0] miss_total
);

  rpbc_pkg::rpbc_cmd_t    cmd;
  rpbc_pkg::rpbc_status_t st;

  rpbc_ctrl u_ctrl (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .busy  (busy),
    .st    (st),
    .cmd   (cmd)
  );

  rpbc_datapath u_dp (
    .clk                (clk),
    .rst                (rst),
    .cmd                (cmd),
    .st                 (st),
    .command            (command),
    .logical_block      (logical_block),
    .new_physical_block (new_physical_block),
    .found_block        (found_block),
    .hit                (hit),
    .hit_total          (hit_total),
    .miss_total         (miss_total),
    .done               (done)
  );

endmodule

/* rtl/core/rpbc_ram.sv */
module rpbc_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         din,
  output logic [WIDTH-1:0]         dout
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= din;
    end
    dout <= mem[addr];
  end

endmodule

/* rtl/core/rpbc_ctrl.sv */
module rpbc_ctrl (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   start,
  output logic                   busy,
  input  rpbc_pkg::rpbc_status_t st,
  output rpbc_pkg::rpbc_cmd_t    cmd
);

  typedef enum logic [4:0] {
    S_CLEAR = 5'b00001,
    S_IDLE  = 5'b00010,
    S_PROBE = 5'b00100,
    S_FILL  = 5'b01000,
    S_ZERO  = 5'b10000
  } state_t;

  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  assign busy = (state != S_IDLE);

  always_comb begin
    state_next = state;
    cmd        = '0;
    unique case (state)
      S_CLEAR: begin
        cmd.clear = 1'b1;
        if (st.clear_last) begin
          state_next = S_IDLE;
        end
      end
      S_IDLE: begin
        if (start) begin
          cmd.load   = 1'b1;
          state_next = S_PROBE;
        end
      end
      S_PROBE: begin
        if (!st.is_add) begin
          if (st.hit) begin
            cmd.count_hit = 1'b1;
            cmd.finish    = 1'b1;
            state_next    = S_IDLE;
          end else if (st.chk_valid) begin
            cmd.count_miss = 1'b1;
            if (st.chk_last) begin
              cmd.finish = 1'b1;
              state_next = S_IDLE;
            end else begin
              cmd.probe = 1'b1;
            end
          end else begin
            cmd.probe = 1'b1;
          end
        end else begin
          if (st.add_ok) begin
            cmd.wr_entry = 1'b1;
            cmd.finish   = 1'b1;
            state_next   = S_IDLE;
          end else if (st.chk_last) begin
            state_next = S_FILL;
          end else begin
            cmd.probe = 1'b1;
          end
        end
      end
      S_FILL: begin
        cmd.wr_first = 1'b1;
        if (rpbc_pkg::PROBES == 1) begin
          cmd.finish = 1'b1;
          state_next = S_IDLE;
        end else begin
          state_next = S_ZERO;
        end
      end
      S_ZERO: begin
        cmd.zero_step = 1'b1;
        if (st.zero_last) begin
          cmd.finish = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_CLEAR;
      end
    endcase
  end

endmodule

/* rtl/core/rpbc_datapath.sv */
module rpbc_datapath (
  input  logic                   clk,
  input  logic                   rst,
  input  rpbc_pkg::rpbc_cmd_t    cmd,
  output rpbc_pkg::rpbc_status_t st,
  input  logic                   command,
  input  logic [31:0]            logical_block,
  input  logic [31:0]            new_physical_block,
  output logic [31:0]            found_block,
  output logic                   hit,
  output logic [31:0]            hit_total,
  output logic [31:0]            miss_total,
  output logic                   done
);

  logic                              op;
  logic [31:0]                       key;
  logic [31:0]                       value;
  logic [rpbc_pkg::IDX_W-1:0]        first_slot;
  logic [rpbc_pkg::IDX_W-1:0]        probe_slot;
  logic [rpbc_pkg::PCNT_W-1:0]       probe_idx;
  logic [rpbc_pkg::IDX_W-1:0]        chk_slot;
  logic [rpbc_pkg::PCNT_W-1:0]       chk_idx;
  logic                              chk_valid;
  logic [rpbc_pkg::IDX_W-1:0]        clr_addr;
  logic [31:0]                       hit_counter;
  logic [31:0]                       miss_counter;

  logic [rpbc_pkg::IDX_W-1:0]        ram_addr;
  logic                              tag_we;
  logic                              phys_we;
  logic [31:0]                       tag_din;
  logic [31:0]                       phys_din;
  logic [31:0]                       tag_q;
  logic [31:0]                       phys_q;
  logic [rpbc_pkg::IDX_W-1:0]        probe_slot_next;
  logic [rpbc_pkg::IDX_W-1:0]        first_next;

  assign probe_slot_next = rpbc_pkg::next_slot(
    {{(32 - rpbc_pkg::IDX_W){1'b0}}, probe_slot});
  assign first_next = rpbc_pkg::next_slot(
    {{(32 - rpbc_pkg::IDX_W){1'b0}}, first_slot});

  // single port: clearing, entry writes and probe reads never overlap in use
  always_comb begin
    ram_addr = probe_slot;
    tag_we   = 1'b0;
    phys_we  = 1'b0;
    tag_din  = key;
    phys_din = value;
    priority if (cmd.clear) begin
      ram_addr = clr_addr;
      tag_we   = 1'b1;
      phys_we  = 1'b1;
      tag_din  = '0;
      phys_din = '0;
    end else if (cmd.wr_entry) begin
      ram_addr = chk_slot;
      tag_we   = 1'b1;
      phys_we  = 1'b1;
    end else if (cmd.wr_first) begin
      ram_addr = first_slot;
      tag_we   = 1'b1;
      phys_we  = 1'b1;
    end else if (cmd.zero_step) begin
      phys_we  = (probe_slot != first_slot);
      phys_din = '0;
    end else begin
      ram_addr = probe_slot;
    end
  end

  rpbc_ram #(
    .WIDTH (32),
    .DEPTH (rpbc_pkg::ENTRIES)
  ) u_tag_ram (
    .clk  (clk),
    .we   (tag_we),
    .addr (ram_addr),
    .din  (tag_din),
    .dout (tag_q)
  );

  rpbc_ram #(
    .WIDTH (32),
    .DEPTH (rpbc_pkg::ENTRIES)
  ) u_phys_ram (
    .clk  (clk),
    .we   (phys_we),
    .addr (ram_addr),
    .din  (phys_din),
    .dout (phys_q)
  );

  always_comb begin
    st            = '0;
    st.clear_last = (clr_addr == rpbc_pkg::LAST_SLOT);
    st.is_add     = (op == rpbc_pkg::CMD_ADD);
    st.chk_valid  = chk_valid;
    st.hit        = chk_valid && (op == rpbc_pkg::CMD_LOOKUP) &&
                    (phys_q != '0) && (tag_q == key);
    st.add_ok     = chk_valid && ((phys_q == '0) || (tag_q == key));
    st.chk_last   = chk_valid && (chk_idx == rpbc_pkg::LAST_PROBE);
    st.zero_last  = (probe_idx == rpbc_pkg::LAST_PROBE);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      clr_addr     <= '0;
      chk_valid    <= 1'b0;
      hit_counter  <= '0;
      miss_counter <= '0;
      done         <= 1'b0;
    end else begin
      done <= cmd.finish;
      if (cmd.clear) begin
        clr_addr <= clr_addr + 1'b1;
      end
      if (cmd.load) begin
        chk_valid <= 1'b0;
      end else if (cmd.probe) begin
        chk_valid <= (probe_idx != rpbc_pkg::END_PROBE);
      end
      if (cmd.count_hit) begin
        hit_counter <= hit_counter + 32'd1;
      end
      if (cmd.count_miss) begin
        miss_counter <= miss_counter + 32'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      op         <= command;
      key        <= logical_block;
      value      <= new_physical_block;
      first_slot <= rpbc_pkg::next_slot(logical_block);
      probe_slot <= rpbc_pkg::next_slot(logical_block);
      probe_idx  <= '0;
    end else if (cmd.probe) begin
      chk_slot <= probe_slot;
      chk_idx  <= probe_idx;
      if (probe_idx != rpbc_pkg::END_PROBE) begin
        probe_slot <= probe_slot_next;
        probe_idx  <= probe_idx + 1'b1;
      end
    end else if (cmd.wr_first) begin
      probe_slot <= first_next;
      probe_idx  <= rpbc_pkg::PCNT_W'(1);
    end else if (cmd.zero_step) begin
      probe_slot <= probe_slot_next;
      probe_idx  <= probe_idx + 1'b1;
    end
    if (cmd.finish) begin
      hit         <= st.hit;
      found_block <= st.hit ? phys_q : 32'd0;
    end
  end

  assign hit_total  = hit_counter;
  assign miss_total = miss_counter;

endmodule

/* rtl/core/rpbc_checker.sv */
module rpbc_checker (
  input logic        clk,
  input logic        rst,
  input logic        start,
  input logic        busy,
  input logic        done,
  input logic [31:0] found_block,
  input logic        hit,
  input logic [31:0] hit_total
);

  // a result only shows once the request has left the engine
  a_done_idle: assert property (@(posedge clk) disable iff (rst)
    done |-> !busy)
    else $error("result strobe while busy");

  a_accept_busy: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> busy)
    else $error("request accepted but busy not raised");

  a_hit_nonzero: assert property (@(posedge clk) disable iff (rst)
    (done && hit) |-> (found_block != 32'd0))
    else $error("hit with empty physical block");

  a_miss_zero: assert property (@(posedge clk) disable iff (rst)
    (done && !hit) |-> (found_block == 32'd0))
    else $error("miss or add with nonzero block");

  a_hit_count: assert property (@(posedge clk) disable iff (rst)
    (done && hit && !$past(rst)) |-> (hit_total == $past(hit_total) + 32'd1))
    else $error("hit counter not advanced on hit");

endmodule

bind rehash_probe_block_cache_core rpbc_checker u_rpbc_checker (
  .clk         (clk),
  .rst         (rst),
  .start       (start),
  .busy        (busy),
  .done        (done),
  .found_block (found_block),
  .hit         (hit),
  .hit_total   (hit_total)
);

/* tb/rpbc_checker.sv */
`timescale 1ns / 100ps
module rpbc_scoreboard
  import rpbc_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  input  logic        busy,
  input  logic        command,
  input  logic [31:0] logical_block,
  input  logic [31:0] new_physical_block,
  input  logic        done,
  input  logic [31:0] found_block,
  input  logic        hit,
  input  logic [31:0] hit_total,
  input  logic [31:0] miss_total,
  output int          errors,
  output int          pending
);

  typedef struct packed {
    logic [31:0] found;
    logic        hit;
    logic [31:0] hits;
    logic [31:0] misses;
  } outcome_t;

  logic [31:0] phys_mirror [ENTRIES];
  logic [31:0] tag_mirror  [ENTRIES];
  logic [31:0] hit_count;
  logic [31:0] miss_count;
  outcome_t    outcome_q [$];
  int          fail_count = 0;

  initial begin
    errors  = 0;
    pending = 0;
  end

  function automatic logic [IDX_W-1:0] rehash(input logic [31:0] v);
    logic [31:0] mix;
    mix = v ^ (v << 3) ^ (v >> 16);
    return mix[IDX_W-1:0];
  endfunction

  function automatic outcome_t lookup_block(input logic [31:0] key);
    logic [31:0] cursor;
    logic        matched;
    outcome_t    res;
    cursor  = key;
    matched = 1'b0;
    res     = '0;
    for (int k = 0; k < PROBES; k++) begin
      if (!matched) begin
        cursor = 32'(rehash(cursor));
        if (phys_mirror[cursor[IDX_W-1:0]] != 32'd0 && tag_mirror[cursor[IDX_W-1:0]] == key) begin
          hit_count = hit_count + 32'd1;
          res.found = phys_mirror[cursor[IDX_W-1:0]];
          res.hit   = 1'b1;
          matched   = 1'b1;
        end else begin
          miss_count = miss_count + 32'd1;
        end
      end
    end
    res.hits   = hit_count;
    res.misses = miss_count;
    return res;
  endfunction

  function automatic outcome_t store_mapping(input logic [31:0] key, input logic [31:0] value);
    logic [31:0]      cursor;
    logic             placed;
    logic [IDX_W-1:0] first;
    outcome_t         res;
    cursor = key;
    placed = 1'b0;
    for (int k = 0; k < PROBES; k++) begin
      if (!placed) begin
        cursor = 32'(rehash(cursor));
        if (phys_mirror[cursor[IDX_W-1:0]] == 32'd0 || tag_mirror[cursor[IDX_W-1:0]] == key) begin
          tag_mirror[cursor[IDX_W-1:0]]  = key;
          phys_mirror[cursor[IDX_W-1:0]] = value;
          placed = 1'b1;
        end
      end
    end
    // chain full: take the first slot, empty the foreign slots behind it
    if (!placed) begin
      first = rehash(key);
      tag_mirror[first]  = key;
      phys_mirror[first] = value;
      cursor = 32'(first);
      for (int k = 1; k < PROBES; k++) begin
        cursor = 32'(rehash(cursor));
        if (tag_mirror[cursor[IDX_W-1:0]] != key)
          phys_mirror[cursor[IDX_W-1:0]] = 32'd0;
      end
    end
    res        = '0;
    res.hits   = hit_count;
    res.misses = miss_count;
    return res;
  endfunction

  task automatic compare(input string name, input logic [31:0] want, input logic [31:0] got);
    if (got !== want) begin
      $error("%s: expected %0h, actual %0h", name, want, got);
      fail_count++;
    end
  endtask

  always @(posedge clk) begin
    outcome_t want;
    if (rst) begin
      for (int i = 0; i < ENTRIES; i++) begin
        phys_mirror[i] = '0;
        tag_mirror[i]  = '0;
      end
      hit_count  = '0;
      miss_count = '0;
      outcome_q.delete();
    end else begin
      // the result leaving now belongs to an older request than one taken now
      if (done) begin
        if (outcome_q.size() == 0) begin
          $error("result with no request waiting");
          fail_count++;
        end else begin
          want = outcome_q.pop_front();
          compare("found_block", want.found, found_block);
          compare("hit", 32'(want.hit), 32'(hit));
          compare("hit_total", want.hits, hit_total);
          compare("miss_total", want.misses, miss_total);
        end
      end
      if (start && !busy) begin
        if (command == CMD_ADD)
          outcome_q.push_back(store_mapping(logical_block, new_physical_block));
        else
          outcome_q.push_back(lookup_block(logical_block));
      end
    end
    errors  <= fail_count;
    pending <= outcome_q.size();
  end

endmodule

/* tb/tb_rehash_probe_block_cache_core.sv */
`timescale 1ns / 100ps
module tb_rehash_probe_block_cache_core;
  import rpbc_pkg::*;

  localparam int CYCLE_LIMIT     = 400000;
  localparam int DRAIN_CYCLES    = 2 * PROBES + 4;
  localparam int RANDOM_REQUESTS = 700;
  localparam int KEY_POOL        = 8;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        start = 1'b0;
  logic        command = CMD_LOOKUP;
  logic [31:0] logical_block = '0;
  logic [31:0] new_physical_block = '0;
  logic        busy;
  logic        done;
  logic [31:0] found_block;
  logic        hit;
  logic [31:0] hit_total;
  logic [31:0] miss_total;
  int          errors;
  int          pending;
  int          cycles = 0;
  int          burst_left = 0;
  logic [31:0] base_keys [KEY_POOL];

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  rehash_probe_block_cache_core uut (
    .clk(clk),
    .rst(rst),
    .start(start),
    .busy(busy),
    .command(command),
    .logical_block(logical_block),
    .new_physical_block(new_physical_block),
    .done(done),
    .found_block(found_block),
    .hit(hit),
    .hit_total(hit_total),
    .miss_total(miss_total)
  );

  rpbc_scoreboard u_scoreboard (
    .clk(clk),
    .rst(rst),
    .start(start),
    .busy(busy),
    .command(command),
    .logical_block(logical_block),
    .new_physical_block(new_physical_block),
    .done(done),
    .found_block(found_block),
    .hit(hit),
    .hit_total(hit_total),
    .miss_total(miss_total),
    .errors(errors),
    .pending(pending)
  );

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("Some tests failed");
      $finish;
    end
  end

  // bits 31:29 and 15:13 never reach the hash, so these keys share one chain
  function automatic logic [31:0] sibling(input logic [31:0] base, input int v);
    logic [5:0] sel;
    sel = 6'(v);
    return base ^ {sel[5:3], 13'b0, sel[2:0], 13'b0};
  endfunction

  task automatic issue(input logic cmd, input logic [31:0] key, input logic [31:0] value);
    int gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 12);
      burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 60) : $urandom_range(1, 8);
      if (gap > 0) begin
        start <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
    start              <= 1'b1;
    command            <= cmd;
    logical_block      <= key;
    new_physical_block <= value;
    do @(posedge clk); while (busy);
  endtask

  task automatic drain();
    start <= 1'b0;
    burst_left = 0;
    do @(posedge clk); while (pending != 0);
  endtask

  initial begin
    logic [31:0] chain_base;
    logic [31:0] key;
    logic [31:0] value;
    logic        cmd;
    int          r;
    int          v;
    int          pick;
    chain_base = 32'h5A3C_8E71;
    for (int i = 0; i < KEY_POOL; i++) base_keys[i] = $urandom;
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    // key zero hashes to slot zero forever: every probe hits the same slot
    issue(CMD_LOOKUP, 32'h0, 32'hFFFF_FFFF);
    issue(CMD_ADD, 32'h0, 32'h0);
    issue(CMD_LOOKUP, 32'h0, 32'h0);
    issue(CMD_ADD, 32'h0, 32'h5);
    issue(CMD_LOOKUP, 32'h0, 32'h0);
    issue(CMD_ADD, 32'h2000_0000, 32'hFFFF_FFFF);
    issue(CMD_LOOKUP, 32'h0, 32'h0);
    issue(CMD_LOOKUP, 32'h2000_0000, 32'h0);
    issue(CMD_ADD, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    issue(CMD_LOOKUP, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    // fill one chain, then overflow it
    for (int i = 0; i < PROBES; i++) issue(CMD_ADD, sibling(chain_base, i), $urandom | 32'h1);
    issue(CMD_LOOKUP, sibling(chain_base, PROBES - 1), 32'h0);
    issue(CMD_LOOKUP, sibling(chain_base, 3), 32'h0);
    issue(CMD_ADD, sibling(chain_base, PROBES), 32'h8000_0001);
    issue(CMD_LOOKUP, sibling(chain_base, PROBES), 32'h0);
    issue(CMD_LOOKUP, sibling(chain_base, PROBES - 1), 32'h0);
    issue(CMD_LOOKUP, sibling(chain_base, 0), 32'h0);
    drain();

    for (int n = 0; n < RANDOM_REQUESTS; n++) begin
      if (n % 150 == 149) base_keys[$urandom_range(0, KEY_POOL - 1)] = $urandom;
      if (n % 230 == 229) drain();
      r = $urandom_range(0, 99);
      if (r < 8) begin
        cmd = ($urandom_range(0, 1) == 0) ? CMD_LOOKUP : CMD_ADD;
        key = $urandom;
      end else begin
        cmd = ($urandom_range(0, 99) < 45) ? CMD_ADD : CMD_LOOKUP;
        v = (r < 20) ? $urandom_range(0, 63) : $urandom_range(0, 11);
        key = sibling(base_keys[$urandom_range(0, KEY_POOL - 1)], v);
      end
      pick = $urandom_range(0, 99);
      if (pick < 5)
        value = 32'h0;
      else if (pick < 8)
        value = 32'hFFFF_FFFF;
      else
        value = $urandom;
      issue(cmd, key, value);
    end

    drain();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (errors == 0 && pending == 0)
      $display("All tests passed");
    else
      $display("Some tests failed");
    $finish;
  end

endmodule
